/* sv/lus_pkg.sv */
// Package for the 3x3 LU solver: word widths, divider latency, context records
// and the fixed-point helpers used by the solver.
// No dependencies.
package lus_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;
	localparam int NUM_W     = W + FRAC_BITS;
	localparam int DIV_LAT   = NUM_W + 2;
	localparam int PW        = 2 * W;
	localparam int SW        = 2 * W + 2;

	typedef logic signed [W-1:0]  word_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] wide_t;

	// context riding alongside the first divider pair
	typedef struct packed {
		logic  valid;
		word_t a11;
		word_t a12;
		word_t a13;
		word_t a22;
		word_t a23;
		word_t a32;
		word_t a33;
		word_t b1;
		word_t b2;
		word_t b3;
	} ctx1_t;

	// context alongside the l32 divider
	typedef struct packed {
		logic  valid;
		logic  sing;
		word_t a11;
		word_t a12;
		word_t a13;
		word_t u22;
		word_t u23;
		word_t r33;
		word_t y1;
		word_t y2;
		word_t b3;
		prod_t p31;
	} ctx2_t;

	// context alongside the z divider
	typedef struct packed {
		logic  valid;
		logic  sing;
		word_t a11;
		word_t a12;
		word_t a13;
		word_t u22;
		word_t u23;
		word_t y1;
		word_t y2;
	} ctx3_t;

	// context alongside the y divider
	typedef struct packed {
		logic  valid;
		logic  sing;
		word_t a11;
		word_t a12;
		word_t a13;
		word_t y1;
		word_t z;
	} ctx4_t;

	// context alongside the x divider
	typedef struct packed {
		logic  valid;
		logic  sing;
		word_t y;
		word_t z;
	} ctx5_t;

	// fixed-point product, floored
	function automatic prod_t fx_mul(input word_t p, input word_t q);
		prod_t r;
		begin
			r = p * q;
			return r >>> FRAC_BITS;
		end
	endfunction

	function automatic wide_t ext_w(input word_t v);
		return {{(SW-W){v[W-1]}}, v};
	endfunction

	function automatic wide_t ext_p(input prod_t v);
		return {{(SW-PW){v[PW-1]}}, v};
	endfunction

	// clamp to the signed word range
	function automatic word_t sat_w(input wide_t v);
		word_t r;
		begin
			if (&v[SW-1:W-1] || ~|v[SW-1:W-1]) begin
				r = v[W-1:0];
			end else if (v[SW-1]) begin
				r = {1'b1, {(W-1){1'b0}}};
			end else begin
				r = {1'b0, {(W-1){1'b1}}};
			end
			return r;
		end
	endfunction

endpackage

/* sv/lus_div.sv */
// Pipelined restoring divider: trunc(num * 2^FRAC_BITS / den), saturated.
// One quotient bit per stage. Depends on lus_pkg.
module lus_div (
	input  logic          clk,
	input  logic          en,
	input  lus_pkg::word_t num,
	input  lus_pkg::word_t den,
	output lus_pkg::word_t quo
);
	import lus_pkg::*;

	logic [W-1:0]     rem_s [NUM_W+1];
	logic [NUM_W-1:0] nq_s  [NUM_W+1];
	logic [W-1:0]     dm_s  [NUM_W+1];
	logic             neg_s [NUM_W+1];
	word_t            quo_q;

	logic [W-1:0]     n_mag;
	logic [W-1:0]     d_mag;
	logic [W:0]       t_k   [NUM_W];
	logic [W:0]       df_k  [NUM_W];
	logic             ge_k  [NUM_W];
	logic [NUM_W-1:0] qlim;
	logic [NUM_W-1:0] qneg;

	assign n_mag = num[W-1] ? (~num + 1'b1) : num;
	assign d_mag = den[W-1] ? (~den + 1'b1) : den;
	assign qlim  = {{(NUM_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
	assign qneg  = ~nq_s[NUM_W] + 1'b1;

	// trial subtract per step
	always_comb begin
		for (int k = 0; k < NUM_W; k++) begin
			t_k[k]  = {rem_s[k], nq_s[k][NUM_W-1]};
			df_k[k] = t_k[k] - {1'b0, dm_s[k]};
			ge_k[k] = t_k[k] >= {1'b0, dm_s[k]};
		end
	end

	// operand stage and one stage per quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= {n_mag, {FRAC_BITS{1'b0}}};
			dm_s[0]  <= d_mag;
			neg_s[0] <= num[W-1] ^ den[W-1];
			for (int k = 0; k < NUM_W; k++) begin
				rem_s[k+1] <= ge_k[k] ? df_k[k][W-1:0] : t_k[k][W-1:0];
				nq_s[k+1]  <= {nq_s[k][NUM_W-2:0], ge_k[k]};
				dm_s[k+1]  <= dm_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// sign and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NUM_W]) begin
				quo_q <= (nq_s[NUM_W] > qlim) ? {1'b1, {(W-1){1'b0}}} : qneg[W-1:0];
			end else begin
				quo_q <= (nq_s[NUM_W] >= qlim) ? {1'b0, {(W-1){1'b1}}}
					: nq_s[NUM_W][W-1:0];
			end
		end
	end

	assign quo = quo_q;

endmodule

/* sv/lu_solve_3x3_top.sv */
// 3x3 linear solver, Doolittle LU without pivoting, signed Q16.16 stream.
// The latency is set by five dividers in series, each producing one quotient bit
// per stage. Throughput: one system per cycle; the whole pipeline holds while the
// output request waits. Reset clears all valid bits asynchronously. Depends on
// lus_pkg, lus_div.
module lu_solve_3x3_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [383:0] s_tdata,  // a11 a12 a13 a21 a22 a23 a31 a32 a33 b1 b2 b3
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // sol_x sol_y sol_z
	output logic         m_tuser   // singular
);
	import lus_pkg::*;

	logic  en;
	word_t in_f [12];

	ctx1_t c1_in;
	ctx1_t c1_s [DIV_LAT];
	ctx2_t c2_in;
	ctx2_t c2_s [DIV_LAT];
	ctx3_t c3_in;
	ctx3_t c3_s [DIV_LAT];
	ctx4_t c4_in;
	ctx4_t c4_s [DIV_LAT];
	ctx5_t c5_in;
	ctx5_t c5_s [DIV_LAT];

	word_t l21, l31, l32, zq, yq, xq;

	ctx1_t ctx_s1;
	prod_t p21a12_s1, p21a13_s1, p31a12_s1, p31a13_s1, p21b1_s1, p31b1_s1;

	word_t r32_s2;
	ctx2_t ctx_s3;
	prod_t p32u23_s3, p32y2_s3;
	word_t u33_s4, y3_s4;
	ctx3_t ctx_s5;
	word_t z_s5;
	prod_t pu23z_s5;
	word_t t_s6;
	ctx4_t ctx_s7;
	word_t y_s7;
	prod_t pa12y_s7, pa13z_s7;
	word_t t_s8;

	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic        m_tuser_q;

	word_t u22_c, u33_c;

	// pipeline advances when the output slot is free or being taken
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			in_f[i] = s_tdata[i*W +: W];
		end
	end

	// first divider pair: l21, l31
	assign c1_in = '{valid: s_tvalid, a11: in_f[0], a12: in_f[1], a13: in_f[2],
		a22: in_f[4], a23: in_f[5], a32: in_f[7], a33: in_f[8],
		b1: in_f[9], b2: in_f[10], b3: in_f[11]};

	lus_div u_div_l21 (.clk, .en, .num(in_f[3]), .den(in_f[0]), .quo(l21));
	lus_div u_div_l31 (.clk, .en, .num(in_f[6]), .den(in_f[0]), .quo(l31));

	// context delay lines matching the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				c1_s[i] <= '0;
				c2_s[i] <= '0;
				c3_s[i] <= '0;
				c4_s[i] <= '0;
				c5_s[i] <= '0;
			end
		end else if (en) begin
			c1_s[0] <= c1_in;
			c2_s[0] <= c2_in;
			c3_s[0] <= c3_in;
			c4_s[0] <= c4_in;
			c5_s[0] <= c5_in;
			for (int i = 1; i < DIV_LAT; i++) begin
				c1_s[i] <= c1_s[i-1];
				c2_s[i] <= c2_s[i-1];
				c3_s[i] <= c3_s[i-1];
				c4_s[i] <= c4_s[i-1];
				c5_s[i] <= c5_s[i-1];
			end
		end
	end

	// s1: products with l21, l31
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s1 <= '0;
		end else if (en) begin
			ctx_s1 <= c1_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p21a12_s1 <= fx_mul(l21, c1_s[DIV_LAT-1].a12);
			p21a13_s1 <= fx_mul(l21, c1_s[DIV_LAT-1].a13);
			p31a12_s1 <= fx_mul(l31, c1_s[DIV_LAT-1].a12);
			p31a13_s1 <= fx_mul(l31, c1_s[DIV_LAT-1].a13);
			p21b1_s1  <= fx_mul(l21, c1_s[DIV_LAT-1].b1);
			p31b1_s1  <= fx_mul(l31, c1_s[DIV_LAT-1].b1);
		end
	end

	// s2: first elimination updates, forward y2
	assign u22_c = sat_w(ext_w(ctx_s1.a22) - ext_p(p21a12_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c2_in <= '0;
		end else if (en) begin
			c2_in.valid <= ctx_s1.valid;
			c2_in.sing  <= (ctx_s1.a11 == '0) || (u22_c == '0);
			c2_in.a11   <= ctx_s1.a11;
			c2_in.a12   <= ctx_s1.a12;
			c2_in.a13   <= ctx_s1.a13;
			c2_in.u22   <= u22_c;
			c2_in.u23   <= sat_w(ext_w(ctx_s1.a23) - ext_p(p21a13_s1));
			c2_in.r33   <= sat_w(ext_w(ctx_s1.a33) - ext_p(p31a13_s1));
			c2_in.y1    <= ctx_s1.b1;
			c2_in.y2    <= sat_w(ext_w(ctx_s1.b2) - ext_p(p21b1_s1));
			c2_in.b3    <= ctx_s1.b3;
			c2_in.p31   <= p31b1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r32_s2 <= sat_w(ext_w(ctx_s1.a32) - ext_p(p31a12_s1));
		end
	end

	lus_div u_div_l32 (.clk, .en, .num(r32_s2), .den(c2_in.u22), .quo(l32));

	// s3: products with l32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s3 <= '0;
		end else if (en) begin
			ctx_s3 <= c2_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p32u23_s3 <= fx_mul(l32, c2_s[DIV_LAT-1].u23);
			p32y2_s3  <= fx_mul(l32, c2_s[DIV_LAT-1].y2);
		end
	end

	// s4: u33 and y3
	assign u33_c = sat_w(ext_w(ctx_s3.r33) - ext_p(p32u23_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c3_in <= '0;
		end else if (en) begin
			c3_in.valid <= ctx_s3.valid;
			c3_in.sing  <= ctx_s3.sing || (u33_c == '0);
			c3_in.a11   <= ctx_s3.a11;
			c3_in.a12   <= ctx_s3.a12;
			c3_in.a13   <= ctx_s3.a13;
			c3_in.u22   <= ctx_s3.u22;
			c3_in.u23   <= ctx_s3.u23;
			c3_in.y1    <= ctx_s3.y1;
			c3_in.y2    <= ctx_s3.y2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u33_s4 <= u33_c;
			y3_s4  <= sat_w(ext_w(ctx_s3.b3)
				- (ext_p(ctx_s3.p31) + ext_p(p32y2_s3)));
		end
	end

	lus_div u_div_z (.clk, .en, .num(y3_s4), .den(u33_s4), .quo(zq));

	// s5: u23 * z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s5 <= '0;
		end else if (en) begin
			ctx_s5 <= c3_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s5     <= zq;
			pu23z_s5 <= fx_mul(c3_s[DIV_LAT-1].u23, zq);
		end
	end

	// s6: numerator for y
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c4_in <= '0;
		end else if (en) begin
			c4_in.valid <= ctx_s5.valid;
			c4_in.sing  <= ctx_s5.sing;
			c4_in.a11   <= ctx_s5.a11;
			c4_in.a12   <= ctx_s5.a12;
			c4_in.a13   <= ctx_s5.a13;
			c4_in.y1    <= ctx_s5.y1;
			c4_in.z     <= z_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6 <= sat_w(ext_w(ctx_s5.y2) - ext_p(pu23z_s5));
		end
	end

	word_t u22_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			u22_s6 <= ctx_s5.u22;
		end
	end

	lus_div u_div_y (.clk, .en, .num(t_s6), .den(u22_s6), .quo(yq));

	// s7: a12 * y and a13 * z
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s7 <= '0;
		end else if (en) begin
			ctx_s7 <= c4_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s7     <= yq;
			pa12y_s7 <= fx_mul(c4_s[DIV_LAT-1].a12, yq);
			pa13z_s7 <= fx_mul(c4_s[DIV_LAT-1].a13, c4_s[DIV_LAT-1].z);
		end
	end

	// s8: numerator for x
	word_t a11_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c5_in <= '0;
		end else if (en) begin
			c5_in.valid <= ctx_s7.valid;
			c5_in.sing  <= ctx_s7.sing;
			c5_in.y     <= y_s7;
			c5_in.z     <= ctx_s7.z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a11_s8 <= ctx_s7.a11;
			t_s8   <= sat_w(ext_w(ctx_s7.y1) - (ext_p(pa12y_s7) + ext_p(pa13z_s7)));
		end
	end

	lus_div u_div_x (.clk, .en, .num(t_s8), .den(a11_s8), .quo(xq));

	// output register; a singular system returns zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= c5_s[DIV_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser_q <= c5_s[DIV_LAT-1].sing;
			m_tdata_q <= c5_s[DIV_LAT-1].sing ? '0
				: {c5_s[DIV_LAT-1].z, c5_s[DIV_LAT-1].y, xq};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a singular result carries a zero solution
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("singular result with non-zero solution");

	// input side is open exactly when the pipeline moves
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow pipeline enable");

	// a held pipeline keeps its valid bits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> ($stable(ctx_s1.valid) && $stable(c3_in.valid)
			&& $stable(c5_in.valid)))
		else $error("pipeline moved while stalled");

endmodule
